// ===== rtl/ase_pkg.sv =====
package ase_pkg;

  // Store geometry
  localparam int DEPTH  = 128;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 8;
  localparam int DATA_W = 32;
  // Width used for count / position compares and address math
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request kinds
  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_PEEK   = 2'd2;
  localparam logic [1:0] KIND_CHANGE = 2'd3;

  // Response status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_BADINDEX = 2'd3;

  typedef struct packed {
    logic [1:0]              kind;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic [1:0]              status;
  } rsp_t;

  // Controller -> datapath
  typedef struct packed {
    logic take;      // request beat accepted this cycle
    logic load_now;  // load response register from decoded result
    logic load_mem;  // load response register from store read data
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic needs_read;  // decoded request is a successful pop or peek
  } dp_stat_t;

endpackage

// ===== rtl/array_stack_engine_top.sv =====
// Bounded LIFO stack engine over a 128-word store.
// Request channel (req_valid/req_ready/req): one beat carries kind, position
// and item_value. Kinds: push, pop, peek at a distance from the top (1 is the
// top), and overwrite at an absolute index (0 is the bottom).
// Response channel (rsp_valid/rsp_ready/rsp): exactly one beat per request,
// in order, carrying read_data (zero unless a pop or peek succeeds) and status
// (ok, overflow, underflow/empty, invalid index).
// Timing: push, change and every failed request answer from the decoded
// result in the cycle after acceptance; a successful pop or peek answers
// through the read state, the registered read port of the word store.
// Throughput: one request in flight at a time. Writes and errors go at one
// beat per cycle with rsp_ready high; a successful read blocks its successor.
// The response register is the boundary between the channels: a new request
// is taken in the same cycle the previous response is taken.
// Reset (rst, synchronous) empties the stack and drops any pending response;
// store contents are not cleared. While a response waits with rsp_ready low
// it holds and req_ready stays low.
module array_stack_engine_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ase_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ase_pkg::rsp_t rsp
);

  ase_pkg::dp_cmd_t  cmd;
  ase_pkg::dp_stat_t stat;

  ase_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ase_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

// ===== rtl/ase_datapath.sv =====
module ase_datapath (
  input  logic             clk,
  input  logic             rst,
  input  ase_pkg::req_t    req,
  input  ase_pkg::dp_cmd_t cmd,
  output ase_pkg::dp_stat_t stat,
  output ase_pkg::rsp_t    rsp
);

  logic [ase_pkg::CNT_W-1:0]  count;
  logic [ase_pkg::CNT_W-1:0]  count_next;
  logic [ase_pkg::DATA_W-1:0] mem [ase_pkg::DEPTH];
  logic [ase_pkg::DATA_W-1:0] mem_q;

  logic [ase_pkg::CMP_W-1:0]  cnt_ext;
  logic [ase_pkg::CMP_W-1:0]  pos_ext;
  logic [ase_pkg::CMP_W-1:0]  rd_off;
  logic [ase_pkg::ADDR_W-1:0] wr_addr;
  logic [ase_pkg::ADDR_W-1:0] rd_addr;
  logic                       wr_en;
  logic                       rd_ok;
  logic [1:0]                 dec_status;

  assign cnt_ext = ase_pkg::CMP_W'(count);
  assign pos_ext = ase_pkg::CMP_W'(req.position);

  // Request decode: bounds checks, store addresses, next count
  always_comb begin
    dec_status = ase_pkg::ST_OK;
    wr_en      = 1'b0;
    rd_ok      = 1'b0;
    wr_addr    = count[ase_pkg::ADDR_W-1:0];
    rd_off     = cnt_ext - ase_pkg::CMP_W'(1);
    count_next = count;
    unique case (req.kind)
      ase_pkg::KIND_PUSH: begin
        if (cnt_ext >= ase_pkg::CMP_W'(ase_pkg::DEPTH)) begin
          dec_status = ase_pkg::ST_OVERFLOW;
        end else begin
          wr_en      = 1'b1;
          count_next = count + ase_pkg::CNT_W'(1);
        end
      end
      ase_pkg::KIND_POP: begin
        if (count == '0) begin
          dec_status = ase_pkg::ST_EMPTY;
        end else begin
          rd_ok      = 1'b1;
          count_next = count - ase_pkg::CNT_W'(1);
        end
      end
      ase_pkg::KIND_PEEK: begin
        rd_off = cnt_ext - pos_ext;
        if (count == '0) begin
          dec_status = ase_pkg::ST_EMPTY;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          dec_status = ase_pkg::ST_BADINDEX;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
        wr_addr = pos_ext[ase_pkg::ADDR_W-1:0];
        if (pos_ext >= cnt_ext) begin
          dec_status = ase_pkg::ST_BADINDEX;
        end else begin
          wr_en = 1'b1;
        end
      end
    endcase
  end

  assign rd_addr         = rd_off[ase_pkg::ADDR_W-1:0];
  assign stat.needs_read = rd_ok;

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.take) begin
      count <= count_next;
    end
  end

  // Word store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) begin
      mem[wr_addr] <= req.item_value;
    end
    if (cmd.take) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (cmd.load_mem) begin
      rsp.read_data <= mem_q;
      rsp.status    <= ase_pkg::ST_OK;
    end else if (cmd.load_now) begin
      rsp.read_data <= '0;
      rsp.status    <= dec_status;
    end
  end

endmodule

// ===== rtl/ase_ctrl.sv =====
module ase_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  ase_pkg::dp_stat_t stat,
  output ase_pkg::dp_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic state;
  logic state_next;
  logic rsp_valid_next;

  // Take a beat only when idle and the response register is free this edge
  assign req_ready    = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign cmd.take     = req_valid && req_ready;
  assign cmd.load_now = cmd.take && !stat.needs_read;
  assign cmd.load_mem = (state == S_LOOK);

  // Next state and response valid
  always_comb begin
    state_next     = state;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      S_IDLE: begin
        if (cmd.take) begin
          if (stat.needs_read) begin
            state_next = S_LOOK;
          end else begin
            rsp_valid_next = 1'b1;
          end
        end
      end
      default: begin
        state_next     = S_IDLE;
        rsp_valid_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Response register is always free while a store read is in flight
  a_look_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |-> !rsp_valid)
    else $error("response pending during store read");

  // A successful pop/peek goes through the read cycle
  a_take_read: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && stat.needs_read) |=> (state == S_LOOK && !rsp_valid))
    else $error("read request did not enter read cycle");

  // Read cycle always produces a response beat
  a_look_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |=> (rsp_valid && state == S_IDLE))
    else $error("read cycle did not present a response");

  // Any other accepted request answers on the next cycle
  a_take_now: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && !stat.needs_read) |=> rsp_valid)
    else $error("direct response missing");

endmodule
